/* src/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// assertion on the block clock and reset
`define ASSERT_DEF(lbl, prop) `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

/* src/ole_pkg.sv */
package ole_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LEN_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_REMOVE     = 3'd2,
    MODE_DEDUP      = 3'd3,
    MODE_SEARCH     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_ABSENT = 2'd2
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] removed;
  } out_item_t;

endpackage

/* src/ordered_list_engine_unit.sv */
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
// out     | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//
// one transaction at a time through a single-port memory and one 32-bit comparator
// push back writes the tail directly; push front, search and remove walk the list entry by entry
// dedup walks the list and compares each entry with the kept ones in an inner compare walk
// in_stall_o is high from acceptance until the result is loaded into the output register
// a stalled result holds in the output register while the next transaction is taken
// reset clears length and the control state; the memory is not cleared
`include "assert_macros.svh"

module ordered_list_engine_unit import ole_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PF_RD   = 4'd1;
  localparam logic [3:0] S_PF_WR   = 4'd2;
  localparam logic [3:0] S_PB      = 4'd3;
  localparam logic [3:0] S_SC_RD   = 4'd4;
  localparam logic [3:0] S_SC_CMP  = 4'd5;
  localparam logic [3:0] S_RM_RD   = 4'd6;
  localparam logic [3:0] S_RM_WR   = 4'd7;
  localparam logic [3:0] S_DD_RD   = 4'd8;
  localparam logic [3:0] S_DD_HOLD = 4'd9;
  localparam logic [3:0] S_DD_KRD  = 4'd10;
  localparam logic [3:0] S_DD_KCMP = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [3:0]        state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] hold_q, hold_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  i_q, i_d;
  logic [LEN_W-1:0]  k_q, k_d;
  logic [LEN_W-1:0]  w_q, w_d;
  status_e           status_q, status_d;
  logic [LEN_W-1:0]  removed_q, removed_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rdata_q;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr;

  logic [LEN_W-1:0]  i_m1;
  logic [DATA_W-1:0] cmp_b;
  logic              match;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign i_m1     = i_q - LEN_W'(1);
  assign cmp_b    = (state_q == S_DD_KCMP) ? hold_q : val_q;
  assign match    = (rdata_q == cmp_b);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    val_d       = val_q;
    hold_d      = hold_q;
    len_d       = len_q;
    i_d         = i_q;
    k_d         = k_q;
    w_d         = w_q;
    status_d    = status_q;
    removed_d   = removed_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = i_q[IDX_W-1:0];
    wdata       = rdata_q;
    raddr       = i_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d    = in_data_i.mode;
          val_d     = in_data_i.value;
          status_d  = STATUS_OK;
          removed_d = '0;
          i_d       = '0;
          k_d       = '0;
          w_d       = '0;
          unique case (in_data_i.mode)
            MODE_PUSH_FRONT: begin
              if (len_q == LEN_W'(CAPACITY)) begin
                status_d = STATUS_FULL;
                state_d  = S_DONE;
              end else begin
                i_d     = len_q;
                state_d = S_PF_RD;
              end
            end
            MODE_PUSH_BACK: begin
              if (len_q == LEN_W'(CAPACITY)) begin
                status_d = STATUS_FULL;
                state_d  = S_DONE;
              end else begin
                state_d = S_PB;
              end
            end
            MODE_REMOVE, MODE_SEARCH: state_d = S_SC_RD;
            MODE_DEDUP:               state_d = S_DD_RD;
            default:                  state_d = S_DONE;
          endcase
        end
      end
      S_PF_RD: begin
        if (i_q == '0) begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = val_q;
          len_d   = len_q + LEN_W'(1);
          state_d = S_DONE;
        end else begin
          raddr   = i_m1[IDX_W-1:0];
          state_d = S_PF_WR;
        end
      end
      S_PF_WR: begin
        we      = 1'b1;
        waddr   = i_q[IDX_W-1:0];
        i_d     = i_m1;
        state_d = S_PF_RD;
      end
      S_PB: begin
        we      = 1'b1;
        waddr   = len_q[IDX_W-1:0];
        wdata   = val_q;
        len_d   = len_q + LEN_W'(1);
        state_d = S_DONE;
      end
      S_SC_RD: begin
        if (i_q == len_q) begin
          status_d = STATUS_ABSENT;
          state_d  = S_DONE;
        end else begin
          state_d = S_SC_CMP;
        end
      end
      S_SC_CMP: begin
        i_d = i_q + LEN_W'(1);
        if (match) begin
          state_d = (mode_q == MODE_SEARCH) ? S_DONE : S_RM_RD;
        end else begin
          state_d = S_SC_RD;
        end
      end
      S_RM_RD: begin
        if (i_q == len_q) begin
          len_d     = len_q - LEN_W'(1);
          removed_d = LEN_W'(1);
          state_d   = S_DONE;
        end else begin
          state_d = S_RM_WR;
        end
      end
      S_RM_WR: begin
        we      = 1'b1;
        waddr   = i_m1[IDX_W-1:0];
        i_d     = i_q + LEN_W'(1);
        state_d = S_RM_RD;
      end
      S_DD_RD: begin
        if (i_q == len_q) begin
          removed_d = len_q - w_q;
          len_d     = w_q;
          state_d   = S_DONE;
        end else begin
          state_d = S_DD_HOLD;
        end
      end
      S_DD_HOLD: begin
        hold_d  = rdata_q;
        k_d     = '0;
        state_d = S_DD_KRD;
      end
      S_DD_KRD: begin
        if (k_q == w_q) begin
          we      = 1'b1;
          waddr   = w_q[IDX_W-1:0];
          wdata   = hold_q;
          w_d     = w_q + LEN_W'(1);
          i_d     = i_q + LEN_W'(1);
          state_d = S_DD_RD;
        end else begin
          raddr   = k_q[IDX_W-1:0];
          state_d = S_DD_KCMP;
        end
      end
      S_DD_KCMP: begin
        if (match) begin
          i_d     = i_q + LEN_W'(1);
          state_d = S_DD_RD;
        end else begin
          k_d     = k_q + LEN_W'(1);
          state_d = S_DD_KRD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.status  = status_q;
          out_d.count   = COUNT_W'(len_q);
          out_d.removed = COUNT_W'(removed_q);
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      w_q         <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      k_q         <= k_d;
      w_q         <= w_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    val_q     <= val_d;
    hold_q    <= hold_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_DEF(a_len_bound, len_q <= LEN_W'(CAPACITY))
  `ASSERT_DEF(a_accept_busy, (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
  `ASSERT_DEF(a_dedup_ptrs,
    (state_q == S_DD_RD || state_q == S_DD_HOLD || state_q == S_DD_KRD ||
     state_q == S_DD_KCMP) |-> (w_q <= i_q && k_q <= w_q))

endmodule

/* sim/tb_ordered_list_engine_unit.sv */
module tb_ordered_list_engine_unit;
  import ole_pkg::*;

  typedef struct {
    in_item_t item;
    bit       drain;
  } pend_t;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b1;
  out_item_t out_data_o;

  ordered_list_engine_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  // shadow list contents, front at index 0
  logic [31:0] list_mem [CAPACITY];
  int          list_len;

  pend_t       pending [$];
  out_item_t   predicted_replies [$];
  pend_t       cur;
  logic [31:0] pool [16];

  bit in_busy;
  bit in_took;
  bit out_took;
  int in_gap;
  int out_hold = 3;
  bit calm [2];
  int calm_left [2];

  int errors;
  int accepted;
  int mode_seen [8];
  int full_drops;
  int misses;
  int peak_len;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic out_item_t apply_list_op(in_item_t op);
    out_item_t res;
    int        hit;
    int        kept;
    int        prior_len;
    bit        dup;
    res.status  = STATUS_OK;
    res.removed = '0;
    hit = -1;
    prior_len = list_len;
    kept = list_len;
    for (int i = 0; i < list_len; i++) begin
      if (hit < 0 && list_mem[i] == op.value) hit = i;
    end
    case (op.mode)
      MODE_PUSH_FRONT: begin
        if (list_len >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = op.value;
          list_len++;
        end
      end
      MODE_PUSH_BACK: begin
        if (list_len >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          list_mem[list_len] = op.value;
          list_len++;
        end
      end
      MODE_REMOVE: begin
        if (hit < 0) begin
          res.status = STATUS_ABSENT;
        end else begin
          for (int i = hit; i < list_len - 1; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          res.removed = COUNT_W'(1);
        end
      end
      MODE_DEDUP: begin
        kept = 0;
        for (int r = 0; r < prior_len; r++) begin
          dup = 1'b0;
          for (int k = 0; k < kept; k++) begin
            if (list_mem[k] == list_mem[r]) dup = 1'b1;
          end
          if (!dup) begin
            list_mem[kept] = list_mem[r];
            kept++;
          end
        end
        list_len = kept;
        res.removed = COUNT_W'(prior_len - kept);
      end
      MODE_SEARCH: begin
        if (hit < 0) res.status = STATUS_ABSENT;
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(list_len);
    return res;
  endfunction

  // side 0 is the sender, side 1 the receiver
  function automatic int draw_gap(int side);
    if (calm_left[side] == 0) begin
      calm_left[side] = $urandom_range(10, 50);
      calm[side] = ($urandom_range(0, 3) == 0);
    end
    calm_left[side]--;
    return calm[side] ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic void queue_op(mode_e m, logic [31:0] v, bit drain);
    pend_t p;
    p.item.mode  = m;
    p.item.value = v;
    p.drain      = drain;
    pending.push_back(p);
  endfunction

  // extremes plus values one bit away from earlier entries, or random values
  function automatic void refill_pool();
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 16; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        pool[i] = pool[$urandom_range(0, i - 1)] ^ (32'd1 << $urandom_range(0, 31));
      end else begin
        pool[i] = $urandom;
      end
    end
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 85) return pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_took) begin
        in_took = 1'b0;
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending.size() > 0 &&
                     !(pending[0].drain && predicted_replies.size() > 0)) begin
          cur = pending.pop_front();
          in_busy = 1'b1;
          in_gap = draw_gap(0);
          in_data <= cur.item;
        end
      end
      in_valid <= in_busy;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) begin
        out_took = 1'b0;
        out_hold = draw_gap(1);
      end else if (out_valid_o && out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        predicted_replies.push_back(apply_list_op(in_data));
        mode_seen[in_data.mode]++;
        accepted++;
        in_took = 1'b1;
      end
      if (out_valid_o && !out_stall) begin
        out_took = 1'b1;
        got = out_data_o;
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                   $time, got.status, got.count, got.removed);
          errors++;
        end else begin
          want = predicted_replies.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
          end
          if (got.count !== want.count) begin
            $display("%0t: count mismatch, expected %0d, actual %0d",
                     $time, want.count, got.count);
            errors++;
          end
          if (got.removed !== want.removed) begin
            $display("%0t: removed mismatch, expected %0d, actual %0d",
                     $time, want.removed, got.removed);
            errors++;
          end
          if (want.status == STATUS_FULL) full_drops++;
          if (want.status == STATUS_ABSENT) misses++;
          if (want.count > peak_len) peak_len = want.count;
        end
      end
    end
  end

  initial begin
    seg_e  kind;
    mode_e m;
    int    r;
    int    seg;
    int    seg_len;
    int    total;
    int    c0;
    int    c1;
    int    c2;
    int    c3;

    // empty list corner cases, extremes, duplicates and near misses
    queue_op(MODE_SEARCH,     32'h0000_0005, 1'b0);
    queue_op(MODE_REMOVE,     32'h0000_0005, 1'b0);
    queue_op(MODE_DEDUP,      32'h0000_0000, 1'b0);
    queue_op(MODE_PUSH_FRONT, 32'h8000_0000, 1'b0);
    queue_op(MODE_PUSH_BACK,  32'h7fff_ffff, 1'b0);
    queue_op(MODE_PUSH_BACK,  32'h0000_0000, 1'b0);
    queue_op(MODE_PUSH_FRONT, 32'hffff_ffff, 1'b0);
    queue_op(MODE_PUSH_BACK,  32'h8000_0000, 1'b0);
    queue_op(MODE_PUSH_FRONT, 32'h0000_0000, 1'b0);
    queue_op(MODE_PUSH_BACK,  32'h7fff_fffe, 1'b0);
    queue_op(MODE_SEARCH,     32'h7fff_fffe, 1'b0);
    queue_op(MODE_SEARCH,     32'h0000_0001, 1'b0);
    queue_op(MODE_SEARCH,     32'h8000_0001, 1'b0);
    queue_op(MODE_REMOVE,     32'h0000_0000, 1'b0);
    queue_op(MODE_REMOVE,     32'h1234_5678, 1'b0);
    queue_op(MODE_PUSH_BACK,  32'hffff_ffff, 1'b0);
    queue_op(MODE_DEDUP,      32'hffff_ffff, 1'b0);
    queue_op(MODE_DEDUP,      32'h0000_0000, 1'b0);
    queue_op(MODE_REMOVE,     32'h8000_0000, 1'b0);
    queue_op(MODE_REMOVE,     32'h7fff_ffff, 1'b0);
    queue_op(MODE_SEARCH,     32'hffff_ffff, 1'b0);
    queue_op(MODE_PUSH_FRONT, 32'h5a5a_5a5a, 1'b0);
    queue_op(MODE_SEARCH,     32'h5a5a_5a5a, 1'b0);

    // random segments, first one fills the list past capacity
    total = 0;
    seg = 0;
    while (total < 1750) begin
      refill_pool();
      kind = (seg == 0) ? SEG_FILL : seg_e'($urandom_range(0, 2));
      seg_len = (seg == 0) ? 100 : $urandom_range(30, 90);
      case (kind)
        SEG_FILL: begin
          c0 = 45; c1 = 88; c2 = 92; c3 = 95;
        end
        SEG_DRAIN: begin
          c0 = 10; c1 = 20; c2 = 68; c3 = 80;
        end
        default: begin
          c0 = 25; c1 = 50; c2 = 70; c3 = 78;
        end
      endcase
      for (int j = 0; j < seg_len; j++) begin
        r = $urandom_range(0, 99);
        m = (r < c0) ? MODE_PUSH_FRONT :
            (r < c1) ? MODE_PUSH_BACK :
            (r < c2) ? MODE_REMOVE :
            (r < c3) ? MODE_DEDUP : MODE_SEARCH;
        if (seg == 0 && m == MODE_DEDUP) m = MODE_PUSH_BACK;
        queue_op(m, pick_value(), (j == 0) && (seg == 0 || $urandom_range(0, 2) == 0));
        total++;
      end
      seg++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() > 0 || in_busy) @(posedge clk_i);
    while (predicted_replies.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d transactions: front %0d, back %0d, remove %0d, dedup %0d, search %0d",
             accepted, mode_seen[MODE_PUSH_FRONT], mode_seen[MODE_PUSH_BACK],
             mode_seen[MODE_REMOVE], mode_seen[MODE_DEDUP], mode_seen[MODE_SEARCH]);
    $display("saw %0d dropped inserts on a full list, %0d misses, peak occupancy %0d of %0d",
             full_drops, misses, peak_len, CAPACITY);
    if (errors == 0 && predicted_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
